@@ hw/rtl/twa_pkg.sv @@
package twa_pkg;

    // per-sensor alarm state
    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_ABOVE  = 2'd1,
        ST_BELOW  = 2'd2
    } t_alarm_state;

    // event reported with each result
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ABOVE  = 2'd1,
        EV_BELOW  = 2'd2,
        EV_NORMAL = 2'd3
    } t_alarm_event;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_TEMPS       = 2'd0,
        CFG_MAX_TEMPS       = 2'd1,
        CFG_SENSOR_SETTINGS = 2'd2,
        CFG_SENSOR_COUNT    = 2'd3
    } t_cfg_index;

    // accepted sensor family codes
    localparam logic [7:0] FAM_DS18B20 = 8'h28;
    localparam logic [7:0] FAM_DS1822  = 8'h22;
    localparam logic [7:0] FAM_DS18S20 = 8'h10;

    // bits of a settings byte
    localparam int SET_DRIVE_BIT  = 0;
    localparam int SET_INVERT_BIT = 1;
    localparam int SET_SMS_BIT    = 2;
    localparam int SET_OUT_LSB    = 3;

    localparam logic [63:0] MIN_TEMPS_RST = 64'd236;
    localparam logic [63:0] MAX_TEMPS_RST = 64'd25;

    typedef struct packed {
        t_alarm_event alarm_event;
        logic [4:0]   drive_mask;
        logic         drive_level;
        logic         sms_request;
        t_alarm_state alarm_now;
    } t_result;

endpackage

@@ hw/rtl/temperature_window_alarm.sv @@
// channel  dir  handshake                   payload
// -------  ---  --------------------------  --------------------------------------------------
// reading  in   i_in_valid / o_in_stall     sensor index, family code, temperature, read error
// result   out  o_out_valid / i_out_stall   event, drive mask, drive level, sms request, state
// config   in   i_cfg_we                    i_cfg_index, i_cfg_data
//
// one transfer per cycle on each channel while it is not stalled; a reading is held in the input
// register until its result is loaded into the result register, from which the result transfers
// the state table is written at the edge that loads the result, so back-to-back readings
// of one sensor see each other's state
// synchronous active-low reset: all sensors normal, limits and settings to defaults
// a stalled result holds its register; after one more reading o_in_stall stays high
module temperature_window_alarm
    import twa_pkg::*;
#(
    parameter int MAX_SENSORS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_sensor_index,
    input  logic [7:0]         i_family_code,
    input  logic signed [15:0] i_temperature,
    input  logic               i_read_error,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_alarm_event,
    output logic [4:0]         o_drive_mask,
    output logic               o_drive_level,
    output logic               o_sms_request,
    output logic [1:0]         o_alarm_now,

    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

    // configuration registers
    logic [63:0] r_min_temps;
    logic [63:0] r_max_temps;
    logic [63:0] r_settings;
    logic [3:0]  r_sensor_count;

    // input register
    logic               r_in_valid;
    logic [2:0]         r_in_idx;
    logic [7:0]         r_in_family;
    logic signed [15:0] r_in_temp;
    logic               r_in_err;

    // result register
    logic    r_out_valid;
    t_result r_out;

    // alarm state table
    t_alarm_state r_alarm [MAX_SENSORS];

    logic       out_ready;
    logic       take;
    logic       idx_ok;
    logic [5:0] byte_lsb;
    t_result    n_out;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign take      = r_in_valid && out_ready;
    assign idx_ok    = {1'b0, r_in_idx} < 4'(MAX_SENSORS);
    assign byte_lsb  = {r_in_idx, 3'b000};

    assign o_in_stall = r_in_valid && !out_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_temps    <= MIN_TEMPS_RST;
            r_max_temps    <= MAX_TEMPS_RST;
            r_settings     <= '0;
            r_sensor_count <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MIN_TEMPS:       r_min_temps    <= i_cfg_data;
                CFG_MAX_TEMPS:       r_max_temps    <= i_cfg_data;
                CFG_SENSOR_SETTINGS: r_settings     <= i_cfg_data;
                CFG_SENSOR_COUNT:    r_sensor_count <= i_cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    // input register: loads whenever it is empty or draining this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_idx    <= i_sensor_index;
            r_in_family <= i_family_code;
            r_in_temp   <= i_temperature;
            r_in_err    <= i_read_error;
        end
    end

    // window compare and state step
    twa_eval u_eval (
        .i_idx_ok      (idx_ok),
        .i_count_nz    (r_sensor_count != 4'd0),
        .i_family_code (r_in_family),
        .i_read_error  (r_in_err),
        .i_temperature (r_in_temp),
        .i_min_temp    (r_min_temps[byte_lsb +: 8]),
        .i_max_temp    (r_max_temps[byte_lsb +: 8]),
        .i_settings    (r_settings[byte_lsb +: 8]),
        .i_state       (r_alarm[r_in_idx[IDX_W-1:0]]),
        .o_result      (n_out)
    );

    // state table written at the same edge as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SENSORS; k++) begin
                r_alarm[k] <= ST_NORMAL;
            end
        end else if (take && idx_ok) begin
            r_alarm[r_in_idx[IDX_W-1:0]] <= n_out.alarm_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_alarm_event = r_out.alarm_event;
    assign o_drive_mask  = r_out.drive_mask;
    assign o_drive_level = r_out.drive_level;
    assign o_sms_request = r_out.sms_request;
    assign o_alarm_now   = r_out.alarm_now;

    // the stored state of a sensor matches the state reported for its last reading
    a_state_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && idx_ok) |=> (r_alarm[$past(r_in_idx[IDX_W-1:0])] == r_out.alarm_now))
        else $error("alarm table disagrees with reported state");

    // a held reading is never dropped while the result side stalls
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_ready) |=> r_in_valid)
        else $error("input register lost a reading under stall");

    // an above event leaves the sensor in the above alarm state
    a_event_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.alarm_event == EV_ABOVE)) |-> (r_out.alarm_now == ST_ABOVE))
        else $error("above event without above state");

    // outputs are only driven as part of an event
    a_mask_needs_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.drive_mask != 5'd0)) |-> (r_out.alarm_event != EV_NONE))
        else $error("drive mask without an event");

endmodule

@@ hw/rtl/twa_eval.sv @@
module twa_eval
    import twa_pkg::*;
(
    input  logic               i_idx_ok,
    input  logic               i_count_nz,
    input  logic [7:0]         i_family_code,
    input  logic               i_read_error,
    input  logic signed [15:0] i_temperature,
    input  logic [7:0]         i_min_temp,
    input  logic [7:0]         i_max_temp,
    input  logic [7:0]         i_settings,
    input  t_alarm_state       i_state,
    output t_result            o_result
);

    logic               fam_ok;
    logic               active;
    logic signed [15:0] lim_lo;
    logic signed [15:0] lim_hi;
    logic               above;
    logic               below;
    logic               inv;

    assign fam_ok = (i_family_code == FAM_DS18B20) || (i_family_code == FAM_DS1822)
                 || (i_family_code == FAM_DS18S20);
    assign active = i_idx_ok && i_count_nz && fam_ok && !i_read_error;
    assign lim_lo = {{8{i_min_temp[7]}}, i_min_temp};
    assign lim_hi = {{8{i_max_temp[7]}}, i_max_temp};
    assign above  = i_temperature > lim_hi;
    assign below  = i_temperature < lim_lo;
    assign inv    = i_settings[SET_INVERT_BIT];

    always_comb begin
        o_result             = '0;
        o_result.alarm_event = EV_NONE;
        o_result.alarm_now   = i_idx_ok ? i_state : ST_NORMAL;
        if (active) begin
            if (above || below) begin
                if (i_state == ST_NORMAL) begin
                    o_result.alarm_now   = above ? ST_ABOVE : ST_BELOW;
                    o_result.alarm_event = above ? EV_ABOVE : EV_BELOW;
                    o_result.drive_level = !inv;
                end
            end else if (i_state != ST_NORMAL) begin
                o_result.alarm_now   = ST_NORMAL;
                o_result.alarm_event = EV_NORMAL;
                o_result.drive_level = inv;
            end
            if (o_result.alarm_event != EV_NONE) begin
                if (i_settings[SET_DRIVE_BIT]) begin
                    o_result.drive_mask = i_settings[7:SET_OUT_LSB];
                end
                o_result.sms_request = i_settings[SET_SMS_BIT];
            end
            // level only means something when some output is driven
            if (o_result.drive_mask == 5'd0) begin
                o_result.drive_level = 1'b0;
            end
        end
    end

endmodule

@@ bench/twa_checker.sv @@
module twa_checker
    import twa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [2:0]         i_sensor_index,
    input  logic [7:0]         i_family_code,
    input  logic signed [15:0] i_temperature,
    input  logic               i_read_error,

    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_alarm_event,
    input  logic [4:0]         i_drive_mask,
    input  logic               i_drive_level,
    input  logic               i_sms_request,
    input  logic [1:0]         i_alarm_now,

    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,

    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0]  min_limits;
    logic [63:0]  max_limits;
    logic [63:0]  settings_bytes;
    logic [3:0]   active_count;
    t_alarm_state alarm_table [8];
    t_result      expected_results [$];
    t_result      seen_result;
    t_result      due_result;
    int           fail_count = 0;

    // alarm window decision for one reading, updates the sensor's state
    function automatic t_result judge_reading(input logic [2:0] idx,
                                              input logic [7:0] fam,
                                              input logic signed [15:0] temp,
                                              input logic err);
        t_result             r;
        t_alarm_state        st;
        logic [7:0]          set;
        logic signed [7:0]   hi;
        logic signed [7:0]   lo;
        logic                over;
        logic                under;
        st = alarm_table[idx];
        r = '{alarm_event: EV_NONE, drive_mask: 5'd0, drive_level: 1'b0,
              sms_request: 1'b0, alarm_now: st};
        if (active_count != 4'd0 && !err &&
            (fam == FAM_DS18B20 || fam == FAM_DS1822 || fam == FAM_DS18S20)) begin
            set   = settings_bytes[8*idx +: 8];
            hi    = max_limits[8*idx +: 8];
            lo    = min_limits[8*idx +: 8];
            over  = temp > hi;
            under = temp < lo;
            if (over || under) begin
                // above wins when both limits are crossed
                if (st == ST_NORMAL) begin
                    st = over ? ST_ABOVE : ST_BELOW;
                    r.alarm_event = over ? EV_ABOVE : EV_BELOW;
                    r.drive_level = !set[SET_INVERT_BIT];
                end
            end else if (st != ST_NORMAL) begin
                st = ST_NORMAL;
                r.alarm_event = EV_NORMAL;
                r.drive_level = set[SET_INVERT_BIT];
            end
            if (r.alarm_event != EV_NONE) begin
                if (set[SET_DRIVE_BIT])
                    r.drive_mask = set[SET_OUT_LSB +: 5];
                r.sms_request = set[SET_SMS_BIT];
            end
            if (r.drive_mask == 5'd0)
                r.drive_level = 1'b0;
            alarm_table[idx] = st;
            r.alarm_now = st;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_limits     = MIN_TEMPS_RST;
            max_limits     = MAX_TEMPS_RST;
            settings_bytes = 64'd0;
            active_count   = 4'd0;
            foreach (alarm_table[s])
                alarm_table[s] = ST_NORMAL;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_TEMPS:       min_limits     = i_cfg_data;
                    CFG_MAX_TEMPS:       max_limits     = i_cfg_data;
                    CFG_SENSOR_SETTINGS: settings_bytes = i_cfg_data;
                    CFG_SENSOR_COUNT:    active_count   = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(judge_reading(i_sensor_index, i_family_code,
                                                         i_temperature, i_read_error));
            if (i_out_valid && !i_out_stall) begin
                seen_result = '{alarm_event: t_alarm_event'(i_alarm_event),
                                drive_mask: i_drive_mask, drive_level: i_drive_level,
                                sms_request: i_sms_request,
                                alarm_now: t_alarm_state'(i_alarm_now)};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: ev %0d mask %b lvl %b sms %b now %0d",
                                 seen_result.alarm_event, seen_result.drive_mask,
                                 seen_result.drive_level, seen_result.sms_request,
                                 seen_result.alarm_now);
                end else begin
                    due_result = expected_results.pop_front();
                    if (seen_result !== due_result) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected ev %0d mask %b lvl %b sms %b now %0d, got ev %0d mask %b lvl %b sms %b now %0d",
                                     due_result.alarm_event, due_result.drive_mask,
                                     due_result.drive_level, due_result.sms_request,
                                     due_result.alarm_now,
                                     seen_result.alarm_event, seen_result.drive_mask,
                                     seen_result.drive_level, seen_result.sms_request,
                                     seen_result.alarm_now);
                    end
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import twa_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int QUIET_LIMIT = 5000;
    // readings per configuration round
    localparam int ROUND_READINGS = 48;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;

    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_sensor_index = 3'd0;
    logic [7:0]         i_family_code = 8'd0;
    logic signed [15:0] i_temperature = 16'sd0;
    logic               i_read_error = 1'b0;

    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_alarm_event;
    logic [4:0]         o_drive_mask;
    logic               o_drive_level;
    logic               o_sms_request;
    logic [1:0]         o_alarm_now;

    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = CFG_MIN_TEMPS;
    logic [63:0]        i_cfg_data = 64'd0;

    int                 fail_count;
    int                 results_pending;

    // idle odds for both sides, in percent
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;

    // limits as last written, used to aim readings at the window edges
    logic [63:0]        cur_min = MIN_TEMPS_RST;
    logic [63:0]        cur_max = MAX_TEMPS_RST;

    int                 quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    temperature_window_alarm #(.MAX_SENSORS(8)) dut (.*);

    twa_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_sensor_index (i_sensor_index),
        .i_family_code  (i_family_code),
        .i_temperature  (i_temperature),
        .i_read_error   (i_read_error),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_alarm_event  (o_alarm_event),
        .i_drive_mask   (o_drive_mask),
        .i_drive_level  (o_drive_level),
        .i_sms_request  (o_sms_request),
        .i_alarm_now    (o_alarm_now),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (results_pending)
    );

    // result side back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // hang detector: any transfer on either channel restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one reading transfer, with random idle cycles ahead of it
    // valid is left high afterwards so back-to-back transfers need no extra edge
    task automatic feed_reading(input logic [2:0] idx, input logic [7:0] fam,
                                input logic signed [15:0] temp, input logic err);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sensor_index <= idx;
        i_family_code  <= fam;
        i_temperature  <= temp;
        i_read_error   <= err;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and hold off until every outstanding result has come back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    // register write; only called while the block is idle
    task automatic write_reg(input t_cfg_index idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CFG_MIN_TEMPS)
            cur_min = data;
        if (idx == CFG_MAX_TEMPS)
            cur_max = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one full set of registers; some rounds pin the extremes
    task automatic load_settings_round(input int k);
        logic [63:0] mins;
        logic [63:0] maxs;
        logic [63:0] sets;
        logic [63:0] count_word;
        int          lo_i;
        int          hi_i;
        for (int b = 0; b < 8; b++) begin
            lo_i = int'($urandom_range(60)) - 40;
            hi_i = lo_i + int'($urandom_range(40)) - 5;
            mins[8*b +: 8] = 8'(lo_i);
            maxs[8*b +: 8] = 8'(hi_i);
        end
        // widest possible window
        if (k == 0) begin
            mins = {8{8'h80}};
            maxs = {8{8'h7f}};
        end
        // zero-width window
        if (k == 4) begin
            mins = 64'd0;
            maxs = 64'd0;
        end
        sets = {$urandom, $urandom};
        if (k == 1)
            sets = '1;
        if (k == 2)
            sets = 64'd0;
        // upper data bits are random, only the low nibble counts
        count_word = {$urandom, $urandom};
        case (k)
            3:       count_word[3:0] = 4'd8;
            5:       count_word[3:0] = 4'd15;
            6:       count_word[3:0] = 4'd1;
            7:       count_word[3:0] = 4'd0;
            default: count_word[3:0] = 4'($urandom_range(15, 1));
        endcase
        write_reg(CFG_MIN_TEMPS, mins);
        write_reg(CFG_MAX_TEMPS, maxs);
        write_reg(CFG_SENSOR_SETTINGS, sets);
        write_reg(CFG_SENSOR_COUNT, count_word);
    endtask

    // readings mostly aimed at the limits of the chosen sensor so alarms
    // enter, hold, see readings beyond the opposite limit and return; some noise mixed in
    task automatic random_reading();
        logic [2:0]         idx;
        logic [7:0]         fam;
        logic signed [15:0] temp;
        logic               err;
        logic signed [7:0]  lo;
        logic signed [7:0]  hi;
        int                 pick;
        idx = 3'($urandom_range(7));
        lo  = cur_min[8*idx +: 8];
        hi  = cur_max[8*idx +: 8];
        err = ($urandom_range(99) < 6);
        case ($urandom_range(2))
            0:       fam = FAM_DS18B20;
            1:       fam = FAM_DS1822;
            default: fam = FAM_DS18S20;
        endcase
        if ($urandom_range(99) < 8)
            fam = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)
            temp = 16'($urandom);
        else if (pick < 25)
            temp = 16'((int'(lo) + int'(hi)) / 2);
        else if (pick < 62)
            temp = 16'(int'(hi) + int'($urandom_range(6)) - 3);
        else
            temp = 16'(int'(lo) + int'($urandom_range(6)) - 3);
        feed_reading(idx, fam, temp, err);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 38;
        stall_pct    <= 87;

        // --- directed part ---
        // handling disabled after reset
        feed_reading(3'd0, FAM_DS18B20, 16'sd100, 1'b0);
        wait_results_drained();
        // sensor 0 drives outputs 0,2,4 with sms; sensor 1 drives all, inverted
        write_reg(CFG_SENSOR_SETTINGS, 64'h0000_0000_0000_fbad);
        write_reg(CFG_SENSOR_COUNT, 64'd1);
        // sensor 0 window is -20..25 from reset
        feed_reading(3'd0, FAM_DS18B20, 16'sd26, 1'b0);
        feed_reading(3'd0, FAM_DS18B20, 16'sd25, 1'b0);
        feed_reading(3'd0, FAM_DS1822, -16'sd21, 1'b0);
        // opposite side while below: state kept
        feed_reading(3'd0, FAM_DS18S20, 16'sd30, 1'b0);
        feed_reading(3'd0, FAM_DS18B20, -16'sd20, 1'b0);
        // read error and unknown family are ignored
        feed_reading(3'd0, FAM_DS18B20, 16'sh7fff, 1'b1);
        feed_reading(3'd0, 8'h29, 16'sh7fff, 1'b0);
        feed_reading(3'd0, FAM_DS18B20, 16'sh7fff, 1'b0);
        feed_reading(3'd0, FAM_DS18B20, 16'sh8000, 1'b0);
        feed_reading(3'd0, FAM_DS18B20, 16'sd0, 1'b0);
        // sensor 1 window is 0..0, inverted level
        feed_reading(3'd1, FAM_DS1822, 16'sd1, 1'b0);
        feed_reading(3'd1, FAM_DS1822, 16'sd0, 1'b0);
        feed_reading(3'd1, FAM_DS1822, -16'sd1, 1'b0);
        feed_reading(3'd1, 8'h00, 16'sd0, 1'b0);
        feed_reading(3'd1, 8'hff, 16'sd0, 1'b0);
        feed_reading(3'd1, FAM_DS18S20, 16'sd0, 1'b0);
        wait_results_drained();
        // sensor 7 gets an inverted window so both limits cross at once
        write_reg(CFG_MIN_TEMPS, 64'h0a00_0000_0000_00ec);
        write_reg(CFG_MAX_TEMPS, 64'hf600_0000_0000_0019);
        write_reg(CFG_SENSOR_COUNT, '1);
        feed_reading(3'd7, FAM_DS18B20, 16'sd0, 1'b0);
        feed_reading(3'd7, FAM_DS18B20, 16'sd11, 1'b0);
        feed_reading(3'd7, FAM_DS18B20, -16'sd11, 1'b0);
        wait_results_drained();
        // zero low nibble disables handling; stored state still reported
        write_reg(CFG_SENSOR_COUNT, 64'h10);
        feed_reading(3'd7, FAM_DS18S20, 16'sd0, 1'b0);

        // --- random part: three idle profiles, three register sets each ---
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 38;
                    stall_pct    <= 87;
                end
                1: begin
                    send_idle_pct = 87;
                    stall_pct    <= 38;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
            endcase
            for (int round = 0; round < 3; round++) begin
                wait_results_drained();
                load_settings_round(phase * 3 + round);
                repeat (ROUND_READINGS) random_reading();
            end
        end

        wait_results_drained();
        // pipeline is two deep; give stray results a chance to show
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ temperature_window_alarm.f @@
hw/rtl/twa_pkg.sv
hw/rtl/twa_eval.sv
hw/rtl/temperature_window_alarm.sv
bench/twa_checker.sv
bench/tb_top.sv
